// ===== hw/rtl/apuseq_pkg.sv =====
// ----------------------------------------------------------------------------
// apuseq_pkg
// Shared types, register addresses and lookup tables for the sound control
// sequencer: command codes, register map, length and noise period tables.
// ----------------------------------------------------------------------------
package apuseq_pkg;

  localparam int CFG_W      = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int PWDATA_W   = 32;
  localparam int PERIOD_W   = 11;
  localparam int LEVEL_W    = 4;
  localparam int LEN_W      = 8;
  localparam int LIN_W      = 7;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 8;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes (paddr[2]).
  localparam logic CFG_TICK_INC  = 1'b0;
  localparam logic CFG_FRAME_PER = 1'b1;

  // Register file addresses with side effects.
  localparam logic [ADDR_W-1:0] ADDR_P1_CTL     = 5'h00;
  localparam logic [ADDR_W-1:0] ADDR_P1_LO      = 5'h02;
  localparam logic [ADDR_W-1:0] ADDR_P1_HI      = 5'h03;
  localparam logic [ADDR_W-1:0] ADDR_P2_CTL     = 5'h04;
  localparam logic [ADDR_W-1:0] ADDR_P2_LO      = 5'h06;
  localparam logic [ADDR_W-1:0] ADDR_P2_HI      = 5'h07;
  localparam logic [ADDR_W-1:0] ADDR_TRI_CTL    = 5'h08;
  localparam logic [ADDR_W-1:0] ADDR_TRI_LO     = 5'h0A;
  localparam logic [ADDR_W-1:0] ADDR_TRI_HI     = 5'h0B;
  localparam logic [ADDR_W-1:0] ADDR_NOISE_CTL  = 5'h0C;
  localparam logic [ADDR_W-1:0] ADDR_NOISE_PER  = 5'h0E;
  localparam logic [ADDR_W-1:0] ADDR_NOISE_LEN  = 5'h0F;
  localparam logic [ADDR_W-1:0] ADDR_STATUS     = 5'h15;
  localparam logic [ADDR_W-1:0] ADDR_FRAME      = 5'h17;

  // Shortest pulse period that still sounds.
  localparam logic [PERIOD_W-1:0] MIN_PULSE_PERIOD = 11'h008;

  typedef struct packed {
    logic [LEVEL_W-1:0] decay;
    logic [LEVEL_W-1:0] divider;
    logic               restart;
  } env_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  pulse1_level;
    logic [1:0]          pulse1_duty;
    logic [PERIOD_W-1:0] pulse1_period;
    logic [LEVEL_W-1:0]  pulse2_level;
    logic [1:0]          pulse2_duty;
    logic [PERIOD_W-1:0] pulse2_period;
    logic                tri_active;
    logic [PERIOD_W-1:0] tri_period;
    logic [LEVEL_W-1:0]  noise_level;
    logic [PERIOD_W-1:0] noise_period;
  } result_t;

  function automatic logic [LEN_W-1:0] len_lookup(input logic [4:0] idx);
    logic [LEN_W-1:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PERIOD_W-1:0] noise_lookup(input logic [3:0] idx);
    logic [PERIOD_W-1:0] v;
    case (idx)
      4'd0:  v = 11'h002;  4'd1:  v = 11'h004;  4'd2:  v = 11'h008;  4'd3:  v = 11'h010;
      4'd4:  v = 11'h020;  4'd5:  v = 11'h030;  4'd6:  v = 11'h040;  4'd7:  v = 11'h050;
      4'd8:  v = 11'h065;  4'd9:  v = 11'h07F;  4'd10: v = 11'h0BE;  4'd11: v = 11'h0FE;
      4'd12: v = 11'h17D;  4'd13: v = 11'h1FC;  4'd14: v = 11'h3F9;  4'd15: v = 11'h7F2;
      default: v = 11'h000;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/apuseq_env.sv =====
// ----------------------------------------------------------------------------
// apuseq_env
// One envelope unit: restart, divider countdown and decay level, clocked by
// quarter-frame events. Purely combinational next-state logic.
// ----------------------------------------------------------------------------
module apuseq_env
  import apuseq_pkg::*;
(
  input  env_state_t         cur,
  input  logic [DATA_W-1:0]  ctl,
  input  logic               enable,
  input  logic               quarter,
  output env_state_t         nxt,
  output logic [LEVEL_W-1:0] vol
);

  always_comb begin
    nxt = cur;
    if (enable && quarter) begin
      if (cur.restart) begin
        nxt.decay   = 4'hF;
        nxt.divider = ctl[3:0];
        nxt.restart = 1'b0;
      end else if (cur.divider != 4'h0) begin
        nxt.divider = cur.divider - 4'h1;
      end else begin
        nxt.divider = ctl[3:0];
        if (cur.decay != 4'h0) begin
          nxt.decay = cur.decay - 4'h1;
        end else if (ctl[5]) begin
          nxt.decay = 4'hF;
        end
      end
    end
    // Constant volume mode bypasses the decay counter.
    vol = ctl[4] ? ctl[3:0] : nxt.decay;
  end

endmodule

// ===== hw/rtl/apu_envelope_length_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// apu_envelope_length_frame_sequencer
// Control section of a four-channel sound chip: register file, envelopes,
// length counters, triangle linear counter and a 4/5-step frame sequencer.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high and returns
// exactly one result per item. An item is either a register write (in_cmd
// low) or a sample tick (in_cmd high). Each accepted item is first captured
// in an input register; once the skid entry is free, the second stage does
// the whole state update (register file, phase accumulator, frame sequencer,
// envelopes, length and linear counters, output latches) in one pass and
// writes the resulting channel outputs into a two-entry output buffer. An
// item thus passes the input register and then the output buffer before
// its result is presented on the output ports. The output buffer
// is a result register backed by a skid entry, so the block keeps taking
// items while one result waits on a stalled consumer; in_ready drops only
// when the input register and both buffer entries are full. Levels, duties
// and the triangle active flag reflect the last tick; periods follow writes
// at once. The two configuration registers (tick increment and frame period)
// sit on an APB-style port at byte addresses 0 and 4 and must be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module apu_envelope_length_frame_sequencer
  import apuseq_pkg::*;
#(
  parameter int NUM_REGS  = 32,
  parameter int ACC_WIDTH = 21
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [ADDR_W-1:0]     in_reg_addr,
  input  logic [DATA_W-1:0]     in_write_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_pulse1_level,
  output logic [1:0]            out_pulse1_duty,
  output logic [PERIOD_W-1:0]   out_pulse1_period,
  output logic [LEVEL_W-1:0]    out_pulse2_level,
  output logic [1:0]            out_pulse2_duty,
  output logic [PERIOD_W-1:0]   out_pulse2_period,
  output logic                  out_tri_active,
  output logic [PERIOD_W-1:0]   out_tri_period,
  output logic [LEVEL_W-1:0]    out_noise_level,
  output logic [PERIOD_W-1:0]   out_noise_period,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [PWDATA_W-1:0]   cfg_pwdata,
  output logic [PWDATA_W-1:0]   cfg_prdata,
  output logic                  cfg_pready
);

  // Register file index width and the width used for accumulator math.
  localparam int RF_AW = $clog2(NUM_REGS);
  localparam int CW    = (ACC_WIDTH > CFG_W) ? ACC_WIDTH : CFG_W;

  // Configuration registers.
  logic [CFG_W-1:0] tick_inc_r;
  logic [CFG_W-1:0] frame_per_r;

  // Input stage.
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // Architectural state.
  logic [DATA_W-1:0]   reg_file_r   [NUM_REGS];
  logic [ACC_WIDTH-1:0] acc_r,       acc_nxt;
  logic [2:0]          step_r,       step_nxt;
  logic [LEN_W-1:0]    len_r        [4];
  logic [LEN_W-1:0]    len_nxt      [4];
  env_state_t          env_r        [3];
  env_state_t          env_nxt      [3];
  env_state_t          env_tick     [3];
  logic [LEVEL_W-1:0]  env_vol      [3];
  logic [LIN_W-1:0]    lin_r,        lin_nxt;
  logic                lin_reload_r, lin_reload_nxt;
  logic [PERIOD_W-1:0] period_r     [4];
  logic [PERIOD_W-1:0] period_nxt   [4];
  logic [1:0]          duty_r       [2];
  logic [1:0]          duty_nxt     [2];
  logic [LEVEL_W-1:0]  level_r      [2];
  logic [LEVEL_W-1:0]  level_nxt    [2];
  logic                tri_active_r, tri_active_nxt;
  logic [LEVEL_W-1:0]  noise_lvl_r,  noise_lvl_nxt;

  // Output buffer: result register plus one skid entry.
  result_t out_r;
  result_t skid_r;
  result_t res;
  logic    out_valid_r;
  logic    skid_valid_r;

  logic in_fire;
  logic s1_fire;
  logic out_take;
  logic is_tick;
  logic is_write;
  logic rf_wr_en;
  logic quarter;
  logic half;

  logic [DATA_W-1:0] status;
  logic [DATA_W-1:0] frame_ctl;
  logic [DATA_W-1:0] tri_ctl;
  logic [DATA_W-1:0] ch_ctl [3];

  logic [CW-1:0]        acc_sum;
  logic [ACC_WIDTH-1:0] acc_wrap;
  logic [2:0]           step_inc;
  logic [2:0]           step_last;

  // --------------------------------------------------------------------------
  // Handshake. The second stage fires whenever the skid entry is free, which
  // guarantees room for its result in the output buffer.
  // --------------------------------------------------------------------------
  assign s1_fire  = s1_valid_r && !skid_valid_r;
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  assign is_tick  = s1_fire && (s1_cmd_r == CMD_TICK);
  assign is_write = s1_fire && (s1_cmd_r == CMD_WRITE);
  assign rf_wr_en = is_write && ({1'b0, s1_addr_r} < (ADDR_W + 1)'(NUM_REGS));

  // Fixed register file taps used by the tick logic.
  assign status    = reg_file_r[RF_AW'(ADDR_STATUS)];
  assign frame_ctl = reg_file_r[RF_AW'(ADDR_FRAME)];
  assign tri_ctl   = reg_file_r[RF_AW'(ADDR_TRI_CTL)];
  assign ch_ctl[0] = reg_file_r[RF_AW'(ADDR_P1_CTL)];
  assign ch_ctl[1] = reg_file_r[RF_AW'(ADDR_P2_CTL)];
  assign ch_ctl[2] = reg_file_r[RF_AW'(ADDR_NOISE_CTL)];

  // --------------------------------------------------------------------------
  // Phase accumulator and frame sequencer. When the accumulator reaches the
  // frame period the sequencer takes one step; bit 7 of the frame control
  // register selects the five-step pattern.
  // --------------------------------------------------------------------------
  always_comb begin
    acc_sum   = CW'(acc_r) + CW'(tick_inc_r);
    acc_wrap  = ACC_WIDTH'(acc_sum);
    step_inc  = step_r + 3'd1;
    step_last = frame_ctl[7] ? 3'd5 : 3'd4;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    quarter   = 1'b0;
    half      = 1'b0;
    if (is_tick) begin
      acc_nxt = acc_wrap;
      if (CW'(acc_wrap) >= CW'(frame_per_r)) begin
        acc_nxt = ACC_WIDTH'(CW'(acc_wrap) - CW'(frame_per_r));
        quarter = !(step_inc == 3'd4 && frame_ctl[7]);
        half    = (step_inc == 3'd2) || (step_inc >= step_last);
        step_nxt = (step_inc >= step_last) ? 3'd0 : step_inc;
      end
    end else if (is_write && s1_addr_r == ADDR_FRAME) begin
      acc_nxt  = '0;
      step_nxt = 3'd0;
    end
  end

  // Envelope units: pulse 1, pulse 2 and noise.
  apuseq_env u_env_p1 (
    .cur     (env_r[0]),
    .ctl     (ch_ctl[0]),
    .enable  (status[0]),
    .quarter (quarter),
    .nxt     (env_tick[0]),
    .vol     (env_vol[0])
  );

  apuseq_env u_env_p2 (
    .cur     (env_r[1]),
    .ctl     (ch_ctl[1]),
    .enable  (status[1]),
    .quarter (quarter),
    .nxt     (env_tick[1]),
    .vol     (env_vol[1])
  );

  apuseq_env u_env_noise (
    .cur     (env_r[2]),
    .ctl     (ch_ctl[2]),
    .enable  (status[3]),
    .quarter (quarter),
    .nxt     (env_tick[2]),
    .vol     (env_vol[2])
  );

  // --------------------------------------------------------------------------
  // Channel state update for ticks and register writes.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [1:0] ch;
    ch             = s1_addr_r[3:2];
    len_nxt        = len_r;
    env_nxt        = env_r;
    lin_nxt        = lin_r;
    lin_reload_nxt = lin_reload_r;
    period_nxt     = period_r;
    duty_nxt       = duty_r;
    level_nxt      = level_r;
    tri_active_nxt = tri_active_r;
    noise_lvl_nxt  = noise_lvl_r;

    if (is_tick) begin
      env_nxt = env_tick;

      // Pulse channels: a disabled channel is frozen and latches silence.
      for (int i = 0; i < 2; i++) begin
        if (!status[i]) begin
          level_nxt[i] = '0;
        end else begin
          if (!ch_ctl[i][5] && half && len_r[i] != '0) begin
            len_nxt[i] = len_r[i] - 8'd1;
          end
          if (len_nxt[i] == '0 || period_r[i] < MIN_PULSE_PERIOD) begin
            level_nxt[i] = '0;
          end else begin
            level_nxt[i] = env_vol[i];
            duty_nxt[i]  = ch_ctl[i][7:6];
          end
        end
      end

      // Triangle: linear counter on quarter frames, length on half frames.
      if (!status[2]) begin
        tri_active_nxt = 1'b0;
      end else begin
        if (quarter) begin
          if (lin_reload_r) begin
            lin_nxt = tri_ctl[6:0];
          end else if (lin_r != '0) begin
            lin_nxt = lin_r - 7'd1;
          end
          if (!tri_ctl[7]) begin
            lin_reload_nxt = 1'b0;
          end
        end
        if (half && !tri_ctl[7] && len_r[2] != '0) begin
          len_nxt[2] = len_r[2] - 8'd1;
        end
        tri_active_nxt = (len_nxt[2] != '0) && (lin_nxt != '0);
      end

      // Noise: same envelope and length path as the pulses, no period gate.
      if (!status[3]) begin
        noise_lvl_nxt = '0;
      end else begin
        if (!ch_ctl[2][5] && half && len_r[3] != '0) begin
          len_nxt[3] = len_r[3] - 8'd1;
        end
        noise_lvl_nxt = (len_nxt[3] != '0) ? env_vol[2] : '0;
      end
    end else if (is_write) begin
      case (s1_addr_r)
        ADDR_P1_LO, ADDR_P2_LO, ADDR_TRI_LO: begin
          period_nxt[ch][7:0] = s1_data_r;
        end
        ADDR_P1_HI, ADDR_P2_HI, ADDR_TRI_HI: begin
          period_nxt[ch][10:8] = s1_data_r[2:0];
          len_nxt[ch]          = len_lookup(s1_data_r[7:3]);
          if (s1_addr_r == ADDR_TRI_HI) begin
            lin_reload_nxt = 1'b1;
          end else begin
            env_nxt[ch].restart = 1'b1;
          end
        end
        ADDR_NOISE_PER: begin
          period_nxt[3] = noise_lookup(s1_data_r[3:0]);
        end
        ADDR_NOISE_LEN: begin
          env_nxt[2].restart = 1'b1;
          len_nxt[3]         = len_lookup(s1_data_r[7:3]);
        end
        ADDR_STATUS: begin
          for (int i = 0; i < 4; i++) begin
            if (!s1_data_r[i]) begin
              len_nxt[i] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the item in the second stage, taken from the updated state.
  always_comb begin
    res.pulse1_level  = level_nxt[0];
    res.pulse1_duty   = duty_nxt[0];
    res.pulse1_period = period_nxt[0];
    res.pulse2_level  = level_nxt[1];
    res.pulse2_duty   = duty_nxt[1];
    res.pulse2_period = period_nxt[1];
    res.tri_active    = tri_active_nxt;
    res.tri_period    = period_nxt[2];
    res.noise_level   = noise_lvl_nxt;
    res.noise_period  = period_nxt[3];
  end

  // --------------------------------------------------------------------------
  // State registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file_r[i] <= '0;
      end
      acc_r        <= '0;
      step_r       <= '0;
      len_r        <= '{default: '0};
      env_r        <= '{default: '0};
      lin_r        <= '0;
      lin_reload_r <= 1'b0;
      period_r     <= '{default: '0};
      duty_r       <= '{default: '0};
      level_r      <= '{default: '0};
      tri_active_r <= 1'b0;
      noise_lvl_r  <= '0;
    end else begin
      if (rf_wr_en) begin
        reg_file_r[s1_addr_r[RF_AW-1:0]] <= s1_data_r;
      end
      acc_r        <= acc_nxt;
      step_r       <= step_nxt;
      len_r        <= len_nxt;
      env_r        <= env_nxt;
      lin_r        <= lin_nxt;
      lin_reload_r <= lin_reload_nxt;
      period_r     <= period_nxt;
      duty_r       <= duty_nxt;
      level_r      <= level_nxt;
      tri_active_r <= tri_active_nxt;
      noise_lvl_r  <= noise_lvl_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_cmd;
      s1_addr_r <= in_reg_addr;
      s1_data_r <= in_write_data;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer. A new result goes to the result register when it is free
  // or being emptied, otherwise to the skid entry; the skid entry drains
  // into the result register first.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (s1_fire) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (s1_fire) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pulse1_level  = out_r.pulse1_level;
  assign out_pulse1_duty   = out_r.pulse1_duty;
  assign out_pulse1_period = out_r.pulse1_period;
  assign out_pulse2_level  = out_r.pulse2_level;
  assign out_pulse2_duty   = out_r.pulse2_duty;
  assign out_pulse2_period = out_r.pulse2_period;
  assign out_tri_active    = out_r.tri_active;
  assign out_tri_period    = out_r.tri_period;
  assign out_noise_level   = out_r.noise_level;
  assign out_noise_period  = out_r.noise_period;

  // --------------------------------------------------------------------------
  // Configuration port. Zero wait states; the register index is paddr[2].
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_inc_r  <= CFG_W'(240);
      frame_per_r <= CFG_W'(44100);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[2])
        CFG_TICK_INC:  tick_inc_r  <= cfg_pwdata[CFG_W-1:0];
        CFG_FRAME_PER: frame_per_r <= cfg_pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      CFG_TICK_INC:  cfg_prdata = PWDATA_W'(tick_inc_r);
      CFG_FRAME_PER: cfg_prdata = PWDATA_W'(frame_per_r);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/apuseq_checker.sv =====
// ----------------------------------------------------------------------------
// apuseq_checker
// Port-level checks for the sequencer: reset, output buffering behavior and
// configuration read-back. Bound to the top level below.
// ----------------------------------------------------------------------------
module apuseq_checker
  import apuseq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_W-1:0]    out_pulse1_level,
  input logic [PERIOD_W-1:0]   out_pulse1_period,
  input logic                  out_tri_active,
  input logic [LEVEL_W-1:0]    out_noise_level,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [PWDATA_W-1:0]   cfg_pwdata,
  input logic [PWDATA_W-1:0]   cfg_prdata
);

  // Reset empties the pipeline and reopens the input side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A fresh result leaves the skid entry free, so input is still taken.
  a_ready_on_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input blocked while only one result is buffered");

  // With the buffer full and the consumer stalled, nothing can drain.
  a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_valid && !out_ready |=> !in_ready)
    else $error("input reopened without a result transfer");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse1_level) &&
      $stable(out_pulse1_period) && $stable(out_tri_active) && $stable(out_noise_level))
    else $error("stalled result changed");

  // A configuration write is read back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk)
    (rst_n && cfg_psel && cfg_penable && cfg_pwrite) ##1
      (cfg_psel && !cfg_pwrite && (cfg_paddr[2] == $past(cfg_paddr[2])))
      |-> cfg_prdata == {12'h000, $past(cfg_pwdata[19:0])})
    else $error("configuration read-back mismatch");

endmodule

bind apu_envelope_length_frame_sequencer apuseq_checker u_apuseq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pulse1_level  (out_pulse1_level),
  .out_pulse1_period (out_pulse1_period),
  .out_tri_active    (out_tri_active),
  .out_noise_level   (out_noise_level),
  .cfg_psel          (cfg_psel),
  .cfg_penable       (cfg_penable),
  .cfg_pwrite        (cfg_pwrite),
  .cfg_paddr         (cfg_paddr),
  .cfg_pwdata        (cfg_pwdata),
  .cfg_prdata        (cfg_prdata)
);
